// ----- src/lkvc_pkg.sv -----
// Package: shared constants and types for the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;
  localparam int CAPACITY_MAX = 16;
  localparam int KEY_BITS     = 32;
  localparam int VALUE_BITS   = 32;
  localparam int SLOT_BITS    = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
  localparam int COUNT_BITS   = $clog2(CAPACITY_MAX + 1);
  localparam int CAP_BITS     = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Slot record held in the memory: key, value, recency rank.
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_BITS-1:0]  rank;
  } slot_t;
  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;
endpackage

// ----- src/lkvc_if.sv -----
// Interfaces: request and result channels.
`timescale 1ns / 1ps
interface lkvc_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [lkvc_pkg::KEY_BITS-1:0]   lookup_key;
  logic signed [lkvc_pkg::VALUE_BITS-1:0] write_value;
  modport source (output valid, cmd, lookup_key, write_value, input ready);
  modport sink   (input valid, cmd, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic signed [lkvc_pkg::VALUE_BITS-1:0] read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

// ----- src/lkvc_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/lru_key_value_cache_unit.sv -----
// Top level: fully associative LRU key-value cache.
`timescale 1ns / 1ps
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | cmd, lookup_key, write_value
//  rsp     | out | valid/ready  | hit, read_value
//  cfg     | in  | cfg_we       | cfg_wdata = capacity_in_use
// A taken request runs a read sweep over the slot memory (registered read)
// that matches the key and finds the least recent slot, then a write-back
// sweep over every slot updating ranks, then a commit state. The single
// memory port walks every slot twice per request.
// Reset clears valid bits and entry count and sets the capacity to 16;
// memory contents are left undefined. The result sits in an output register;
// the next request is accepted only after it is taken, so the block does not
// take a new request before it is through with the last one.
module lru_key_value_cache_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  lkvc_req_if.sink                              req,
  lkvc_rsp_if.source                            rsp,
  input  logic                                  cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0]         cfg_wdata
);
  localparam int SB = lkvc_pkg::SLOT_BITS;
  localparam int CB = lkvc_pkg::COUNT_BITS;
  localparam int N  = lkvc_pkg::CAPACITY_MAX;

  typedef enum logic [3:0] {
    P_IDLE  = 4'b0001,
    P_SCAN  = 4'b0010,
    P_WRITE = 4'b0100,
    P_DONE  = 4'b1000
  } phase_t;

  phase_t phase;
  logic [lkvc_pkg::CAP_BITS-1:0] capacity;
  logic [N-1:0] valid;
  logic [CB-1:0] count;

  // Latched request.
  logic cmd;
  logic [lkvc_pkg::KEY_BITS-1:0]   key;
  logic [lkvc_pkg::VALUE_BITS-1:0] wval;

  // Sweep bookkeeping.
  logic [CB-1:0] idx;          // slot currently addressed
  logic          rd_pend;      // read data for slot idx-1 arrives
  logic [SB-1:0] rd_slot;
  logic          found;
  logic [SB-1:0] hit_slot;
  logic [SB-1:0] hit_rank;
  logic [lkvc_pkg::VALUE_BITS-1:0] hit_val;
  logic          have_old;
  logic [SB-1:0] old_slot;
  logic          have_free;
  logic [SB-1:0] free_slot;

  lkvc_pkg::slot_t rdata, wdata;
  logic           we;
  logic [SB-1:0]  waddr, raddr;

  lkvc_ram #(.WIDTH(lkvc_pkg::SLOT_W), .DEPTH(N)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Effective capacity clamped to 1..N.
  logic [CB-1:0] cap_eff;
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CB'(1);
    end else if (32'(capacity) > N) begin
      cap_eff = CB'(N);
    end else begin
      cap_eff = CB'(capacity);
    end
  end

  // A new-key put with the store full evicts; since evictions repeat until
  // count < cap, all slots with rank >= cap-1 drop.
  logic is_insert, evict;
  logic [CB-1:0] keep_ranks;  // ranks below this survive
  assign is_insert  = (cmd == lkvc_pkg::CMD_PUT) && !found;
  assign evict      = is_insert && (count >= cap_eff);
  assign keep_ranks = evict ? (cap_eff - CB'(1)) : count;

  logic [SB-1:0] tgt_slot;
  logic           tgt_ok;
  always_comb begin
    // Target slot: the hit slot on a hit, the eviction candidate when evicting, else a free slot.
    tgt_ok = 1'b1;
    if (found) begin
      tgt_slot = hit_slot;
    end else if (evict) begin
      tgt_slot = old_slot;
    end else begin
      tgt_slot = free_slot;
      tgt_ok   = have_free;
    end
  end

  // Write-back sweep: read slot, rewrite rank next cycle.
  logic          wr_keep;
  logic [SB-1:0] new_rank;
  always_comb begin
    wr_keep  = 1'b0;
    new_rank = rdata.rank;
    if (found) begin
      if (rdata.rank < hit_rank) begin
        new_rank = rdata.rank + SB'(1);
      end
      wr_keep = 1'b1;
    end else if (is_insert) begin
      wr_keep  = (CB'(rdata.rank) < keep_ranks);
      new_rank = rdata.rank + SB'(1);
    end
  end

  assign req.ready = (phase == P_IDLE) && !rsp.valid;
  assign raddr = idx[SB-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = rd_slot;
    wdata = rdata;
    if (phase == P_WRITE && rd_pend && valid[rd_slot] && rd_slot != tgt_slot) begin
      we         = (cmd == lkvc_pkg::CMD_PUT && !found) || found;
      wdata.rank = new_rank;
    end
    if (phase == P_DONE && (cmd == lkvc_pkg::CMD_PUT || found) && tgt_ok) begin
      we          = 1'b1;
      waddr       = tgt_slot;
      wdata.key   = key;
      wdata.value = (cmd == lkvc_pkg::CMD_PUT) ? wval : hit_val;
      wdata.rank  = '0;
    end
  end

  // Track which slots survive eviction during the write sweep.
  logic [N-1:0] drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_IDLE;
      capacity  <= lkvc_pkg::CAP_RESET;
      valid     <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
      drop      <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (phase)
        P_IDLE: begin
          if (req.valid && req.ready) begin
            cmd       <= req.cmd;
            key       <= req.lookup_key;
            wval      <= req.write_value;
            idx       <= '0;
            rd_pend   <= 1'b0;
            found     <= 1'b0;
            have_old  <= 1'b0;
            have_free <= 1'b0;
            drop      <= '0;
            phase     <= P_SCAN;
          end
        end
        P_SCAN: begin
          rd_pend <= (32'(idx) < N);
          rd_slot <= idx[SB-1:0];
          if (32'(idx) < N) begin
            idx <= idx + CB'(1);
          end
          if (rd_pend) begin
            if (valid[rd_slot]) begin
              if (rdata.key == key) begin
                found    <= 1'b1;
                hit_slot <= rd_slot;
                hit_rank <= rdata.rank;
                hit_val  <= rdata.value;
              end
              if (CB'(rdata.rank) >= cap_eff - CB'(1) && !have_old) begin
                have_old <= 1'b1;
                old_slot <= rd_slot;
              end
            end else if (!have_free) begin
              have_free <= 1'b1;
              free_slot <= rd_slot;
            end
          end
          if (!rd_pend && 32'(idx) >= N) begin
            idx   <= '0;
            phase <= P_WRITE;
          end
        end
        P_WRITE: begin
          rd_pend <= (32'(idx) < N);
          rd_slot <= idx[SB-1:0];
          if (32'(idx) < N) begin
            idx <= idx + CB'(1);
          end
          if (rd_pend && valid[rd_slot] && is_insert && !wr_keep) begin
            drop[rd_slot] <= 1'b1;
          end
          if (!rd_pend && 32'(idx) >= N) begin
            phase <= P_DONE;
          end
        end
        default: begin // P_DONE
          if (is_insert) begin
            valid          <= (valid & ~drop) | (N'(1) << tgt_slot);
            count          <= CB'($countones(valid & ~drop)) + CB'(1);
          end
          rsp.hit        <= found;
          rsp.read_value <= (cmd == lkvc_pkg::CMD_PUT) ? '0 :
                            (found ? hit_val : '1);
          rsp.valid      <= 1'b1;
          phase          <= P_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- verif/lkvc_tb_pkg.sv -----
// Test package: request record used by the stimulus queue.
`timescale 1ns / 1ps
package lkvc_tb_pkg;
  import lkvc_pkg::*;

  typedef struct packed {
    logic                   cmd;
    logic [KEY_BITS-1:0]    key;
    logic [VALUE_BITS-1:0]  value;
  } cache_req_t;
endpackage

// ----- verif/tb_top.sv -----
// Testbench for the LRU key-value cache: random get/put traffic checked against an LRU predictor.
`timescale 1ns / 1ps
module tb_top;
  import lkvc_pkg::*;
  import lkvc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CAP_BITS-1:0] cfg_wdata = '0;

  lkvc_req_if req ();
  lkvc_rsp_if rsp ();

  lru_key_value_cache_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req.sink),
    .rsp       (rsp.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a mirror of the cache contents and recency order.
  logic [KEY_BITS-1:0]   mirror_key   [CAPACITY_MAX];
  logic [VALUE_BITS-1:0] mirror_value [CAPACITY_MAX];
  logic                  mirror_valid [CAPACITY_MAX];
  int                    mirror_rank  [CAPACITY_MAX];
  int                    mirror_count;
  int                    capacity_now;

  cache_req_t            pending_reqs[$];
  logic [VALUE_BITS:0]   expected_results[$];  // {hit, read_value}
  int                    mismatches;
  bit                    quiet_phase;

  // Work out the result for one request and advance the mirror.
  function automatic logic [VALUE_BITS:0] predict_access(cache_req_t r);
    int slot;
    int cap;
    int old_rank;
    logic [VALUE_BITS-1:0] rd;
    slot = -1;
    for (int i = 0; i < CAPACITY_MAX; i++)
      if (mirror_valid[i] && mirror_key[i] == r.key && slot < 0) slot = i;
    if (slot >= 0) begin
      // Promote: entries more recent than this one age by one.
      old_rank = mirror_rank[slot];
      for (int i = 0; i < CAPACITY_MAX; i++)
        if (mirror_valid[i] && i != slot && mirror_rank[i] < old_rank)
          mirror_rank[i]++;
      mirror_rank[slot] = 0;
      rd = mirror_value[slot];
      if (r.cmd == CMD_PUT) begin
        mirror_value[slot] = r.value;
        return {1'b1, {VALUE_BITS{1'b0}}};
      end
      return {1'b1, rd};
    end
    if (r.cmd == CMD_GET) return {1'b0, {VALUE_BITS{1'b1}}};
    cap = capacity_now < 1 ? 1 : (capacity_now > CAPACITY_MAX ? CAPACITY_MAX : capacity_now);
    // Evict least recent entries until there is room.
    while (mirror_count >= cap) begin
      for (int i = 0; i < CAPACITY_MAX; i++)
        if (mirror_valid[i] && mirror_rank[i] == mirror_count - 1) begin
          mirror_valid[i] = 1'b0;
          break;
        end
      mirror_count--;
    end
    for (int i = 0; i < CAPACITY_MAX; i++)
      if (!mirror_valid[i]) begin
        for (int j = 0; j < CAPACITY_MAX; j++)
          if (mirror_valid[j]) mirror_rank[j]++;
        mirror_valid[i] = 1'b1;
        mirror_key[i]   = r.key;
        mirror_value[i] = r.value;
        mirror_rank[i]  = 0;
        mirror_count++;
        break;
      end
    return {1'b0, {VALUE_BITS{1'b0}}};
  endfunction

  // Driver: hold a request until accepted, insert random idle bursts.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap  <= 0;
    end else if (req.valid && !req.ready) begin
      // hold
    end else if (send_gap > 0) begin
      req.valid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      cache_req_t r;
      r = pending_reqs.pop_front();
      req.valid       <= 1'b1;
      req.cmd         <= r.cmd;
      req.lookup_key  <= r.key;
      req.write_value <= r.value;
      expected_results.push_back(predict_access(r));
      if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 15);
    end else begin
      req.valid <= 1'b0;
    end
  end

  // Monitor: compare each taken result with the oldest expectation.
  int sink_gap;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      sink_gap  <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result hit=%0b value=%h", $time, rsp.hit, rsp.read_value);
          mismatches++;
        end else begin
          logic [VALUE_BITS:0] exp_r;
          exp_r = expected_results.pop_front();
          if (exp_r[VALUE_BITS] !== rsp.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp_r[VALUE_BITS], rsp.hit);
            mismatches++;
          end
          if (exp_r[VALUE_BITS-1:0] !== rsp.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     exp_r[VALUE_BITS-1:0], rsp.read_value);
            mismatches++;
          end
        end
      end
      if (sink_gap > 0) begin
        rsp.ready <= 1'b0;
        sink_gap  <= sink_gap - 1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        sink_gap  <= $urandom_range(0, 14);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Key pool: small sets so hits, updates and evictions are frequent.
  logic [KEY_BITS-1:0] key_pool[24];

  task automatic queue_req(logic cmd, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    pending_reqs.push_back('{cmd: cmd, key: k, value: v});
  endtask

  // Drain all traffic, then let the block settle before a register write.
  task automatic drain_and_set_capacity(logic [CAP_BITS-1:0] cap);
    wait (pending_reqs.size() == 0 && expected_results.size() == 0 && !req.valid);
    repeat (2 * CAPACITY_MAX + 8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity_now = cap;
  endtask

  task automatic random_phase(int n, int pool_used);
    for (int i = 0; i < n; i++) begin
      logic [KEY_BITS-1:0] k;
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = key_pool[$urandom_range(0, pool_used - 1)];
      queue_req(1'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] caps[6];
    mismatches   = 0;
    quiet_phase  = 1'b0;
    mirror_count = 0;
    capacity_now = CAP_RESET;
    for (int i = 0; i < CAPACITY_MAX; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_rank[i]  = 0;
    end
    req.valid       = 1'b0;
    req.cmd         = CMD_GET;
    req.lookup_key  = '0;
    req.write_value = '0;
    rsp.ready       = 1'b0;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0000_0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: miss on empty, extreme keys and values, update, hit.
    queue_req(CMD_GET, key_pool[0], '0);
    queue_req(CMD_PUT, key_pool[0], 32'h7fff_ffff);
    queue_req(CMD_PUT, key_pool[1], 32'h8000_0000);
    queue_req(CMD_PUT, key_pool[2], 32'hffff_ffff);
    queue_req(CMD_PUT, key_pool[3], 32'h0000_0000);
    queue_req(CMD_GET, key_pool[0], 32'h1234_5678);
    queue_req(CMD_GET, key_pool[2], '0);
    queue_req(CMD_PUT, key_pool[1], 32'h5555_aaaa);
    queue_req(CMD_GET, key_pool[1], '0);
    queue_req(CMD_GET, 32'h0000_0001, '0);
    // Fill past full at capacity 16 to force eviction of the least recent.
    for (int i = 4; i < 19; i++) queue_req(CMD_PUT, key_pool[i], $urandom());
    queue_req(CMD_GET, key_pool[3], '0);
    queue_req(CMD_GET, key_pool[0], '0);

    // Lower capacity while full, then zero and over-range settings.
    caps = '{5'd3, 5'd0, 5'd1, 5'd31, 5'd7, 5'd16};
    foreach (caps[c]) begin
      drain_and_set_capacity(caps[c]);
      random_phase(140, (caps[c] == 0 || caps[c] == 1) ? 3 : 24);
    end
    drain_and_set_capacity(5'd12);
    quiet_phase = 1'b1;
    random_phase(60, 20);
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (2 * CAPACITY_MAX + 8) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
